[sv/bcpd_pkg.sv]
// shared types, constants and helpers for the balance cascade controller
package bcpd_pkg;

  // default bound of the velocity error integrator
  localparam int SUM_LIMIT_DEF = 10000;

  // shared multiplier geometry
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // accumulator width, also holds the combined raw drive
  localparam int ACC_W = 56;

  // state widths
  localparam int FE_W = 20;
  localparam int ES_W = 15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // floor(2^23 / 10), used with a single correction step
  localparam int RECIP10       = 838860;
  localparam int RECIP10_SHIFT = 23;
  localparam int DIVISOR       = 10;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MID_ANGLE      = 3'd0,
    REG_SPEED_SETPOINT = 3'd1,
    REG_ANGLE_KP       = 3'd2,
    REG_ANGLE_KD       = 3'd3,
    REG_SPEED_KP       = 3'd4,
    REG_SPEED_KI       = 3'd5,
    REG_DRIVE_LIMIT    = 3'd6
  } bcpd_reg_t;

  // register reset values
  localparam logic signed [16:0] MID_ANGLE_RST      = 17'sd0;
  localparam logic signed [16:0] SPEED_SETPOINT_RST = 17'sd0;
  localparam logic signed [20:0] ANGLE_KP_RST       = 21'sd51200;
  localparam logic signed [20:0] ANGLE_KD_RST       = 21'sd0;
  localparam logic signed [20:0] SPEED_KP_RST       = 21'sd0;
  localparam logic signed [20:0] SPEED_KI_RST       = 21'sd0;
  localparam logic        [15:0] DRIVE_LIMIT_RST    = 16'd7200;

  // sequencer steps, one per cycle unless waiting at idle or stalled
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KP,
    ST_MUL_KD,
    ST_SUM_A,
    ST_ANGLE,
    ST_DIV_FIX,
    ST_SUM_E,
    ST_MUL_SKP,
    ST_MUL_SKI,
    ST_SUM_S,
    ST_SPEED,
    ST_MUL_CMB,
    ST_CMB,
    ST_SAT
  } bcpd_state_t;

  // sequencer to datapath control
  typedef struct packed {
    bcpd_state_t step;
    logic        take_in;
    logic        load_out;
  } bcpd_ctrl_t;

  // configuration registers as a group
  typedef struct packed {
    logic signed [16:0] mid_angle;
    logic signed [16:0] speed_setpoint;
    logic signed [20:0] angle_kp;
    logic signed [20:0] angle_kd;
    logic signed [20:0] speed_kp;
    logic signed [20:0] speed_ki;
    logic        [15:0] drive_limit;
  } bcpd_cfg_t;

  // input transaction
  typedef struct packed {
    logic signed [16:0] pitch;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] enc_left;
    logic signed [15:0] enc_right_raw;
  } bcpd_in_t;

  // result transaction
  typedef struct packed {
    logic signed [16:0] drive;
    logic signed [31:0] angle_term;
    logic signed [31:0] speed_term;
    logic               drive_saturated;
  } bcpd_out_t;

  // signed shift right by k with rounding toward zero
  function automatic logic signed [ACC_W-1:0] trunc_shift(
    input logic signed [ACC_W-1:0] v,
    input int unsigned             k
  );
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? $signed((ACC_W'(1) << k) - ACC_W'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

endpackage

[sv/balance_cascade_pd_pi_controller.sv]
// top level of the balance cascade controller: ports, registers, result buffer
//
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall   bcpd_in_t  (pitch, gyro, encoders)
// out_     output     out_valid / out_stall bcpd_out_t (drive, loop terms, clip)
// cfg_     input      cfg_valid / cfg_ready index 3 bits, data 21 bits
//
// one transaction steps one shared multiplier through six products and their
// sums, plus a reciprocal divide by ten with correction
// the next input is taken once the sequencer is back at idle, even while the
// previous result still waits
// a stalled result holds the sequencer in its last step until the buffer frees
// synchronous active-low reset clears the sequencer, loop state and registers
module balance_cascade_pd_pi_controller #(
  parameter int SUM_LIMIT = bcpd_pkg::SUM_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bcpd_pkg::bcpd_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bcpd_pkg::bcpd_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bcpd_pkg::bcpd_ctrl_t ctrl;
  bcpd_pkg::bcpd_cfg_t  cfg_r;
  bcpd_pkg::bcpd_out_t  result;
  bcpd_pkg::bcpd_out_t  out_data_r;
  logic                 out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = ctrl.step != bcpd_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_angle      <= bcpd_pkg::MID_ANGLE_RST;
      cfg_r.speed_setpoint <= bcpd_pkg::SPEED_SETPOINT_RST;
      cfg_r.angle_kp       <= bcpd_pkg::ANGLE_KP_RST;
      cfg_r.angle_kd       <= bcpd_pkg::ANGLE_KD_RST;
      cfg_r.speed_kp       <= bcpd_pkg::SPEED_KP_RST;
      cfg_r.speed_ki       <= bcpd_pkg::SPEED_KI_RST;
      cfg_r.drive_limit    <= bcpd_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcpd_pkg::REG_MID_ANGLE:      cfg_r.mid_angle      <= cfg_data[16:0];
        bcpd_pkg::REG_SPEED_SETPOINT: cfg_r.speed_setpoint <= cfg_data[16:0];
        bcpd_pkg::REG_ANGLE_KP:       cfg_r.angle_kp       <= cfg_data[20:0];
        bcpd_pkg::REG_ANGLE_KD:       cfg_r.angle_kd       <= cfg_data[20:0];
        bcpd_pkg::REG_SPEED_KP:       cfg_r.speed_kp       <= cfg_data[20:0];
        bcpd_pkg::REG_SPEED_KI:       cfg_r.speed_ki       <= cfg_data[20:0];
        bcpd_pkg::REG_DRIVE_LIMIT:    cfg_r.drive_limit    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bcpd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .out_valid (out_valid_r),
    .ctrl      (ctrl)
  );

  bcpd_dp #(
    .SUM_LIMIT (SUM_LIMIT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_data (in_data),
    .cfg     (cfg_r),
    .result  (result)
  );

  // result buffer valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (ctrl.load_out) out_data_r <= result;
  end

`ifndef NO_ASSERTIONS
  // an accepted transaction keeps the input side busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after acceptance");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || !out_stall))
    else $error("result buffer overwritten while stalled");

  // a result shows up only from the last sequencer step
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.step == bcpd_pkg::ST_SAT))
    else $error("result valid raised outside the final step");
`endif

endmodule

[sv/bcpd_mul.sv]
// shared signed multiplier with registered product
module bcpd_mul (
  input  logic                                clk,
  input  logic signed [bcpd_pkg::MUL_A_W-1:0] a,
  input  logic signed [bcpd_pkg::MUL_B_W-1:0] b,
  output logic signed [bcpd_pkg::PROD_W-1:0]  prod_r
);

  logic signed [bcpd_pkg::PROD_W-1:0] prod_nxt;

  // full-width signed product
  assign prod_nxt = bcpd_pkg::PROD_W'(a) * bcpd_pkg::PROD_W'(b);

  // product register, one multiply per cycle
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[sv/bcpd_seq.sv]
// step sequencer for the shared datapath
module bcpd_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_stall,
  input  logic                 out_valid,
  output bcpd_pkg::bcpd_ctrl_t ctrl
);

  bcpd_pkg::bcpd_state_t state_r;
  bcpd_pkg::bcpd_state_t state_nxt;
  logic                  out_free;

  assign out_free = !out_valid || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcpd_pkg::ST_IDLE:    if (in_valid) state_nxt = bcpd_pkg::ST_MUL_KP;
      bcpd_pkg::ST_MUL_KP:  state_nxt = bcpd_pkg::ST_MUL_KD;
      bcpd_pkg::ST_MUL_KD:  state_nxt = bcpd_pkg::ST_SUM_A;
      bcpd_pkg::ST_SUM_A:   state_nxt = bcpd_pkg::ST_ANGLE;
      bcpd_pkg::ST_ANGLE:   state_nxt = bcpd_pkg::ST_DIV_FIX;
      bcpd_pkg::ST_DIV_FIX: state_nxt = bcpd_pkg::ST_SUM_E;
      bcpd_pkg::ST_SUM_E:   state_nxt = bcpd_pkg::ST_MUL_SKP;
      bcpd_pkg::ST_MUL_SKP: state_nxt = bcpd_pkg::ST_MUL_SKI;
      bcpd_pkg::ST_MUL_SKI: state_nxt = bcpd_pkg::ST_SUM_S;
      bcpd_pkg::ST_SUM_S:   state_nxt = bcpd_pkg::ST_SPEED;
      bcpd_pkg::ST_SPEED:   state_nxt = bcpd_pkg::ST_MUL_CMB;
      bcpd_pkg::ST_MUL_CMB: state_nxt = bcpd_pkg::ST_CMB;
      bcpd_pkg::ST_CMB:     state_nxt = bcpd_pkg::ST_SAT;
      bcpd_pkg::ST_SAT:     if (out_free) state_nxt = bcpd_pkg::ST_IDLE;
      default:              state_nxt = bcpd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl.step     = state_r;
    ctrl.take_in  = 1'b0;
    ctrl.load_out = 1'b0;
    unique case (state_r)
      bcpd_pkg::ST_IDLE: ctrl.take_in  = in_valid;
      bcpd_pkg::ST_SAT:  ctrl.load_out = out_free;
      default: begin
        ctrl.take_in  = 1'b0;
        ctrl.load_out = 1'b0;
      end
    endcase
  end

endmodule

[sv/bcpd_dp.sv]
// controller datapath: operand selection, accumulator, state and saturation
module bcpd_dp #(
  parameter int SUM_LIMIT = bcpd_pkg::SUM_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcpd_pkg::bcpd_ctrl_t ctrl,
  input  bcpd_pkg::bcpd_in_t   in_data,
  input  bcpd_pkg::bcpd_cfg_t  cfg,
  output bcpd_pkg::bcpd_out_t  result
);

  localparam int ACC_W = bcpd_pkg::ACC_W;
  localparam int FE_W  = bcpd_pkg::FE_W;
  localparam int ES_W  = bcpd_pkg::ES_W;
  localparam int Q_W   = bcpd_pkg::PROD_W > 43 ? 20 : 20;
  localparam logic signed [FE_W:0] SumLim = (FE_W + 1)'(SUM_LIMIT);

  // held operands
  logic signed [17:0]        dpitch_r;
  logic signed [15:0]        gyro_r;
  logic signed [18:0]        err_r;
  logic                      xneg_r;
  logic        [23:0]        xmag_r;
  logic        [Q_W-1:0]     q_r;
  logic signed [FE_W-1:0]    fe_r;
  logic signed [ES_W-1:0]    es_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [31:0]        angle_r;
  logic signed [31:0]        speed_r;

  // multiplier interface
  logic signed [bcpd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bcpd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bcpd_pkg::PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]             prod_ext;

  // combinational helpers
  logic signed [17:0]      pitch_x;
  logic signed [17:0]      mid_x;
  logic signed [23:0]      err_x;
  logic signed [23:0]      fe_x;
  logic signed [23:0]      x_sum;
  logic        [23:0]      q_times10;
  logic signed [24:0]      rem;
  logic        [Q_W:0]     q_fixed;
  logic signed [Q_W:0]     fe_full;
  logic signed [FE_W:0]    es_sum;
  logic signed [ES_W-1:0]  es_clamped;
  logic signed [ACC_W-1:0] lim_pos;
  logic signed [ACC_W-1:0] lim_neg;

  bcpd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod_ext = ACC_W'(prod_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.step)
      bcpd_pkg::ST_MUL_KP: begin
        mul_a = bcpd_pkg::MUL_A_W'(dpitch_r);
        mul_b = bcpd_pkg::MUL_B_W'(cfg.angle_kp);
      end
      bcpd_pkg::ST_MUL_KD: begin
        mul_a = bcpd_pkg::MUL_A_W'(gyro_r);
        mul_b = bcpd_pkg::MUL_B_W'(cfg.angle_kd);
      end
      bcpd_pkg::ST_SUM_A: begin
        mul_a = $signed({{(bcpd_pkg::MUL_A_W - 24){1'b0}}, xmag_r});
        mul_b = bcpd_pkg::MUL_B_W'(bcpd_pkg::RECIP10);
      end
      bcpd_pkg::ST_MUL_SKP: begin
        mul_a = bcpd_pkg::MUL_A_W'(fe_r);
        mul_b = bcpd_pkg::MUL_B_W'(cfg.speed_kp);
      end
      bcpd_pkg::ST_MUL_SKI: begin
        mul_a = bcpd_pkg::MUL_A_W'(es_r);
        mul_b = bcpd_pkg::MUL_B_W'(cfg.speed_ki);
      end
      bcpd_pkg::ST_MUL_CMB: begin
        mul_a = bcpd_pkg::MUL_A_W'(speed_r);
        mul_b = bcpd_pkg::MUL_B_W'(cfg.angle_kp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // pitch offset and filter input 3*err + 7*filtered
  assign pitch_x = 18'(in_data.pitch);
  assign mid_x   = 18'(cfg.mid_angle);
  assign err_x   = 24'(err_r);
  assign fe_x    = 24'(fe_r);
  assign x_sum   = (err_x <<< 1) + err_x + (fe_x <<< 3) - fe_x;

  // remainder check after the reciprocal estimate
  assign q_times10 = {1'b0, q_r, 3'b000} + {3'b000, q_r, 1'b0};
  assign rem       = $signed({1'b0, xmag_r}) - $signed({1'b0, q_times10});
  assign q_fixed   = {1'b0, q_r}
                     + ((rem >= 25'(bcpd_pkg::DIVISOR)) ? (Q_W + 1)'(1) : '0);
  assign fe_full   = xneg_r ? -$signed(q_fixed) : $signed(q_fixed);

  // integrator with symmetric clamp
  assign es_sum = (FE_W + 1)'(es_r) + (FE_W + 1)'(fe_r);
  always_comb begin
    priority if (es_sum > SumLim) begin
      es_clamped = ES_W'(SumLim);
    end else if (es_sum < -SumLim) begin
      es_clamped = ES_W'(-SumLim);
    end else begin
      es_clamped = es_sum[ES_W-1:0];
    end
  end

  // loop state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r <= '0;
      es_r <= '0;
    end else begin
      if (ctrl.step == bcpd_pkg::ST_DIV_FIX) fe_r <= fe_full[FE_W-1:0];
      if (ctrl.step == bcpd_pkg::ST_SUM_E) es_r <= es_clamped;
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    unique case (ctrl.step)
      bcpd_pkg::ST_IDLE: begin
        if (ctrl.take_in) begin
          dpitch_r <= pitch_x - mid_x;
          gyro_r   <= in_data.gyro_rate;
          err_r    <= 19'(in_data.enc_left) - 19'(in_data.enc_right_raw)
                      - 19'(cfg.speed_setpoint);
        end
      end
      bcpd_pkg::ST_MUL_KD: begin
        acc_r  <= prod_ext;
        xneg_r <= x_sum[23];
        xmag_r <= x_sum[23] ? 24'(-x_sum) : 24'(x_sum);
      end
      bcpd_pkg::ST_SUM_A:   acc_r <= acc_r + (prod_ext <<< 8);
      bcpd_pkg::ST_ANGLE: begin
        angle_r <= 32'(bcpd_pkg::trunc_shift(acc_r, 16));
        q_r     <= prod_r[bcpd_pkg::RECIP10_SHIFT + Q_W - 1:bcpd_pkg::RECIP10_SHIFT];
      end
      bcpd_pkg::ST_MUL_SKI: acc_r <= prod_ext;
      bcpd_pkg::ST_SUM_S:   acc_r <= acc_r + prod_ext;
      bcpd_pkg::ST_SPEED:   speed_r <= 32'(bcpd_pkg::trunc_shift(acc_r, 8));
      bcpd_pkg::ST_CMB:     acc_r <= ACC_W'(angle_r) - bcpd_pkg::trunc_shift(prod_ext, 8);
      default: begin
      end
    endcase
  end

  // symmetric saturation of the combined drive
  assign lim_pos = $signed({{(ACC_W - 16){1'b0}}, cfg.drive_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    result.angle_term = angle_r;
    result.speed_term = speed_r;
    priority if (acc_r > lim_pos) begin
      result.drive           = lim_pos[16:0];
      result.drive_saturated = 1'b1;
    end else if (acc_r < lim_neg) begin
      result.drive           = lim_neg[16:0];
      result.drive_saturated = 1'b1;
    end else begin
      result.drive           = acc_r[16:0];
      result.drive_saturated = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // one correction step is enough after the reciprocal estimate
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step == bcpd_pkg::ST_DIV_FIX |->
      (rem >= 25'sd0 && rem < 25'(2 * bcpd_pkg::DIVISOR)))
    else $error("divide by ten remainder out of range");

  // integrator never leaves its clamp band
  a_es_band: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step == bcpd_pkg::ST_MUL_SKP |->
      ((FE_W + 1)'(es_r) <= SumLim && (FE_W + 1)'(es_r) >= -SumLim))
    else $error("error sum outside clamp band");
`endif

endmodule
